[src/polar_complex_alu_defines.svh]
// Assertion macros for the polar complex ALU.
`ifndef POLAR_COMPLEX_ALU_DEFINES_SVH
`define POLAR_COMPLEX_ALU_DEFINES_SVH

`ifndef SYNTHESIS
`define PCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PCA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PCA_ASSERT(name, prop, msg)
`define PCA_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

[src/pca_pkg.sv]
`default_nettype none
package pca_pkg;

  localparam int unsigned MAG_W        = 32;
  localparam int unsigned ANG_W        = 16;
  localparam int unsigned MAG_FRAC     = MAG_W / 2;
  localparam int unsigned TURN_W       = 32;
  localparam int unsigned XY_W         = 38;
  localparam int unsigned GAIN_W       = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam logic [TURN_W-1:0] HALF_TURN = {1'b1, {(TURN_W-1){1'b0}}};

  localparam int unsigned CORDIC_ITERS = 16;
  // two micro-rotations per register stage
  localparam int unsigned CORDIC_STGS  = CORDIC_ITERS / 2;
  // two quotient bits per register stage
  localparam int unsigned DIV_STGS     = MAG_W / 2;

  localparam int unsigned STG_SUM    = CORDIC_STGS + 2;
  localparam int unsigned STG_GAIN   = STG_SUM + CORDIC_STGS + 1;
  localparam int unsigned STG_RES    = STG_GAIN + 1;
  localparam int unsigned PIPE_DEPTH = STG_RES + 2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_DIVZERO
  } status_e;

  typedef logic [PIPE_DEPTH-1:0] stage_en_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [TURN_W-1:0]      t;
  } cordic_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ANG_W-1:0] ang;
    status_e          status;
  } result_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic cordic_t rot_step(input cordic_t c, input logic [4:0] i);
    cordic_t r;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    x  = c.x;
    y  = c.y;
    xs = x >>> i;
    ys = y >>> i;
    if (!c.t[TURN_W-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.t = c.t - atan_turn(i);
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.t = c.t + atan_turn(i);
    end
    return r;
  endfunction

  function automatic cordic_t vec_step(input cordic_t c, input logic [4:0] i);
    cordic_t r;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    x  = c.x;
    y  = c.y;
    xs = x >>> i;
    ys = y >>> i;
    if (!y[XY_W-1]) begin
      r.x = x + ys;
      r.y = y - xs;
      r.t = c.t + atan_turn(i);
    end else begin
      r.x = x - ys;
      r.y = y + xs;
      r.t = c.t - atan_turn(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/polar_complex_alu.sv]
// Polar complex ALU: add, subtract, multiply or divide two complex numbers
// given as magnitude (unsigned Q16.16) and angle (signed fraction of a turn).
// Request channel: valid_i, stall_o, opcode_i, a_mag_i, a_ang_i, b_mag_i,
// b_ang_i. Result channel: valid_o, stall_i, res_mag_o, res_ang_o, status_o.
// A request is taken on a rising edge with valid_i high and stall_o low.
// The block is a 22-stage pipeline: two rotating CORDICs, a vectoring CORDIC
// with gain correction, and in parallel a multiplier and a radix-4 divider.
// Throughput is one request per cycle while stall_o stays low.
// Each stage has its own valid bit; a stall_i holds the output register and
// bubbles ahead of it close up, so requests keep entering until every stage
// is full; only then is stall_o raised.
// Reset (rst_ni low, asynchronous) empties the pipeline; there is no other
// state and no startup sweep.
`default_nettype none
`include "polar_complex_alu_defines.svh"
module polar_complex_alu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] a_mag_i,
  input  wire logic [15:0] a_ang_i,
  input  wire logic [31:0] b_mag_i,
  input  wire logic [15:0] b_ang_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      res_mag_o,
  output logic [15:0]      res_ang_o,
  output logic [1:0]       status_o
);
  import pca_pkg::*;

  stage_en_t          en;
  stage_en_t          v_q;
  op_e                op_in;
  op_e                op_q [STG_RES+1];
  logic [TURN_W-1:0]  turn_a;
  logic [TURN_W-1:0]  turn_b;
  cordic_t            xy_a;
  cordic_t            xy_b;
  result_t            polar_res;
  result_t            md_res;
  result_t            res_q;

  always_comb begin
    en[PIPE_DEPTH-1] = !v_q[PIPE_DEPTH-1] || !stall_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign op_in   = op_e'(opcode_i);
  assign turn_a  = {a_ang_i, {(TURN_W-ANG_W){1'b0}}};
  assign turn_b  = {b_ang_i, {(TURN_W-ANG_W){1'b0}}} ^ ((op_in == OP_SUB) ? HALF_TURN : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) op_q[0] <= op_in;
    for (int k = 1; k <= STG_RES; k++) begin
      if (en[k]) op_q[k] <= op_q[k-1];
    end
    if (en[PIPE_DEPTH-1]) begin
      res_q <= (op_q[STG_RES] == OP_ADD || op_q[STG_RES] == OP_SUB) ? polar_res : md_res;
    end
  end

  pca_rect u_rect_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (a_mag_i),
    .turn_i (turn_a),
    .xy_o   (xy_a)
  );

  pca_rect u_rect_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (b_mag_i),
    .turn_i (turn_b),
    .xy_o   (xy_b)
  );

  pca_polar u_polar (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (xy_a),
    .b_i   (xy_b),
    .res_o (polar_res)
  );

  pca_muldiv u_muldiv (
    .clk_i   (clk_i),
    .en_i    (en),
    .op_i    (op_in),
    .a_mag_i (a_mag_i),
    .a_ang_i (a_ang_i),
    .b_mag_i (b_mag_i),
    .b_ang_i (b_ang_i),
    .res_o   (md_res)
  );

  assign valid_o   = v_q[PIPE_DEPTH-1];
  assign res_mag_o = res_q.mag;
  assign res_ang_o = res_q.ang;
  assign status_o  = res_q.status;

  `PCA_ASSERT(a_stall_only_full, stall_o |-> ((&v_q) && stall_i), "stall with empty stage")
  `PCA_ASSERT_NEXT(a_req_enters, valid_i && !stall_o, v_q[0], "accepted request lost")
  `PCA_ASSERT(a_sat_mag, valid_o && (status_o == ST_SAT) |-> (&res_mag_o), "sat not all ones")
  `PCA_ASSERT(a_dz_mag, valid_o && (status_o == ST_DIVZERO) |-> (&res_mag_o), "dz mag bad")

endmodule
`default_nettype wire

[src/pca_rect.sv]
`default_nettype none
module pca_rect (
  input  wire logic                        clk_i,
  input  wire pca_pkg::stage_en_t          en_i,
  input  wire logic [pca_pkg::MAG_W-1:0]   mag_i,
  input  wire logic [pca_pkg::TURN_W-1:0]  turn_i,
  output pca_pkg::cordic_t                 xy_o
);
  import pca_pkg::*;

  logic [MAG_W+GAIN_W-1:0] prod_q;
  logic [TURN_W-1:0]       turn_q;
  cordic_t                 c_q   [CORDIC_STGS+1];
  cordic_t                 c_nxt [CORDIC_STGS];
  cordic_t                 c_init;
  logic signed [XY_W-1:0]  g;

  always_comb begin
    g      = signed'(XY_W'(prod_q[GAIN_W +: MAG_W]));
    c_init = '{x: g, y: '0, t: turn_q};
    // quadrants 1 and 2: pre-rotate by half a turn
    if (turn_q[TURN_W-1] != turn_q[TURN_W-2]) begin
      c_init.x = -g;
      c_init.t = turn_q ^ HALF_TURN;
    end
  end

  always_comb begin
    for (int s = 0; s < CORDIC_STGS; s++) begin
      c_nxt[s] = rot_step(rot_step(c_q[s], 5'(2 * s)), 5'(2 * s + 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= (MAG_W+GAIN_W)'(mag_i) * (MAG_W+GAIN_W)'(INV_GAIN);
      turn_q <= turn_i;
    end
    if (en_i[1]) c_q[0] <= c_init;
    for (int s = 0; s < CORDIC_STGS; s++) begin
      if (en_i[s+2]) c_q[s+1] <= c_nxt[s];
    end
  end

  assign xy_o = c_q[CORDIC_STGS];

endmodule
`default_nettype wire

[src/pca_polar.sv]
`default_nettype none
module pca_polar (
  input  wire logic               clk_i,
  input  wire pca_pkg::stage_en_t en_i,
  input  wire pca_pkg::cordic_t   a_i,
  input  wire pca_pkg::cordic_t   b_i,
  output pca_pkg::result_t        res_o
);
  import pca_pkg::*;

  cordic_t                    c_q    [CORDIC_STGS+1];
  cordic_t                    c_nxt  [CORDIC_STGS];
  logic                       zero_q [CORDIC_STGS+2];
  cordic_t                    c_init;
  logic signed [XY_W-1:0]     sx;
  logic signed [XY_W-1:0]     sy;
  logic [XY_W-2:0]            xc;
  logic [XY_W-1+GAIN_W-1:0]   prod_q;
  logic [TURN_W-1:0]          tg_q;
  logic [XY_W-2:0]            m;
  logic [TURN_W-1:0]          tr;
  result_t                    res_d;
  result_t                    res_q;

  always_comb begin
    sx     = a_i.x + b_i.x;
    sy     = a_i.y + b_i.y;
    c_init = '{x: sx, y: sy, t: '0};
    if (sx[XY_W-1]) begin
      c_init = '{x: -sx, y: -sy, t: HALF_TURN};
    end
  end

  always_comb begin
    for (int s = 0; s < CORDIC_STGS; s++) begin
      c_nxt[s] = vec_step(vec_step(c_q[s], 5'(2 * s)), 5'(2 * s + 1));
    end
  end

  assign xc = c_q[CORDIC_STGS].x[XY_W-1] ? '0 : c_q[CORDIC_STGS].x[XY_W-2:0];

  always_comb begin
    m  = prod_q[GAIN_W +: XY_W-1];
    tr = tg_q + (TURN_W'(1) << (TURN_W - ANG_W - 1));
    res_d.ang    = tr[TURN_W-1 -: ANG_W];
    res_d.mag    = m[MAG_W-1:0];
    res_d.status = ST_OK;
    if (|m[XY_W-2:MAG_W]) begin
      res_d.mag    = '1;
      res_d.status = ST_SAT;
    end
    if (zero_q[CORDIC_STGS+1]) begin
      res_d = '{mag: '0, ang: '0, status: ST_OK};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[STG_SUM]) begin
      c_q[0]    <= c_init;
      zero_q[0] <= (sx == '0) && (sy == '0);
    end
    for (int s = 0; s < CORDIC_STGS; s++) begin
      if (en_i[STG_SUM+1+s]) begin
        c_q[s+1]    <= c_nxt[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
    if (en_i[STG_GAIN]) begin
      prod_q                 <= (XY_W-1+GAIN_W)'(xc) * (XY_W-1+GAIN_W)'(INV_GAIN);
      tg_q                   <= c_q[CORDIC_STGS].t;
      zero_q[CORDIC_STGS+1]  <= zero_q[CORDIC_STGS];
    end
    if (en_i[STG_RES]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

[src/pca_muldiv.sv]
`default_nettype none
module pca_muldiv (
  input  wire logic                      clk_i,
  input  wire pca_pkg::stage_en_t        en_i,
  input  wire pca_pkg::op_e              op_i,
  input  wire logic [pca_pkg::MAG_W-1:0] a_mag_i,
  input  wire logic [pca_pkg::ANG_W-1:0] a_ang_i,
  input  wire logic [pca_pkg::MAG_W-1:0] b_mag_i,
  input  wire logic [pca_pkg::ANG_W-1:0] b_ang_i,
  output pca_pkg::result_t               res_o
);
  import pca_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] dvd;
    logic [MAG_W-1:0] dsr;
  } div_t;

  typedef struct packed {
    op_e              op;
    logic [ANG_W-1:0] ang;
    logic             ovf;
    logic             dz;
    logic [MAG_W-1:0] mul_mag;
    logic             mul_sat;
  } side_t;

  localparam int unsigned RES_STGS = STG_RES - DIV_STGS;

  function automatic div_t div_step(input div_t d);
    div_t           r;
    logic [MAG_W:0] r2;
    r2    = {d.rem, d.dvd[MAG_W-1]};
    r.dsr = d.dsr;
    r.dvd = {d.dvd[MAG_W-2:0], 1'b0};
    if (r2 >= {1'b0, d.dsr}) begin
      r2       = r2 - {1'b0, d.dsr};
      r.dvd[0] = 1'b1;
    end
    r.rem = r2[MAG_W-1:0];
    return r;
  endfunction

  logic [2*MAG_W-1:0] prod_q;
  div_t               div_q  [DIV_STGS+1];
  div_t               div_nxt[DIV_STGS];
  side_t              side_q [DIV_STGS+1];
  side_t              side_1;
  side_t              side_0;
  result_t            res_q  [RES_STGS];
  result_t            res_d;
  side_t              sl;

  always_comb begin
    side_0         = '0;
    side_0.op      = op_i;
    side_0.ang     = (op_i == OP_MUL) ? a_ang_i + b_ang_i : a_ang_i - b_ang_i;
    side_0.ovf     = MAG_W'(a_mag_i[MAG_W-1:MAG_FRAC]) >= b_mag_i;
    side_0.dz      = (b_mag_i == '0);
    side_1         = side_q[0];
    side_1.mul_mag = prod_q[MAG_FRAC +: MAG_W];
    side_1.mul_sat = |prod_q[2*MAG_W-1:MAG_W+MAG_FRAC];
  end

  always_comb begin
    for (int s = 0; s < DIV_STGS; s++) begin
      div_nxt[s] = div_step(div_step(div_q[s]));
    end
  end

  always_comb begin
    sl           = side_q[DIV_STGS];
    res_d.ang    = sl.ang;
    res_d.mag    = div_q[DIV_STGS].dvd;
    res_d.status = ST_OK;
    if (sl.op == OP_MUL) begin
      res_d.mag = sl.mul_mag;
      if (sl.mul_sat) begin
        res_d.mag    = '1;
        res_d.status = ST_SAT;
      end
    end else if (sl.dz) begin
      res_d.mag    = '1;
      res_d.status = ST_DIVZERO;
    end else if (sl.ovf) begin
      res_d.mag    = '1;
      res_d.status = ST_SAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q    <= (2*MAG_W)'(a_mag_i) * (2*MAG_W)'(b_mag_i);
      side_q[0] <= side_0;
      div_q[0]  <= '{rem: MAG_W'(a_mag_i[MAG_W-1:MAG_FRAC]),
                     dvd: {a_mag_i[MAG_FRAC-1:0], {(MAG_W-MAG_FRAC){1'b0}}},
                     dsr: b_mag_i};
    end
    for (int s = 0; s < DIV_STGS; s++) begin
      if (en_i[s+1]) begin
        div_q[s+1]  <= div_nxt[s];
        side_q[s+1] <= (s == 0) ? side_1 : side_q[s];
      end
    end
    if (en_i[DIV_STGS+1]) res_q[0] <= res_d;
    for (int j = 1; j < RES_STGS; j++) begin
      if (en_i[DIV_STGS+1+j]) res_q[j] <= res_q[j-1];
    end
  end

  assign res_o = res_q[RES_STGS-1];

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import pca_pkg::*;

  typedef struct {
    logic [31:0] mag;
    logic [15:0] ang;
    logic [1:0]  status;
  } pol_res_t;

  localparam logic [31:0] ATAN_TBL [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  function automatic logic [63:0] unscale(input logic [63:0] v);
    logic [127:0] p;
    p = v * 128'd652032874;
    return p[93:30];
  endfunction

  function automatic void polar_to_xy(input logic [31:0] mag, input logic [31:0] t,
                                      output longint x, output longint y);
    logic [31:0] turn;
    longint nx;
    turn = t;
    x = longint'(unscale({32'd0, mag}));
    y = 0;
    if (turn[31:30] == 2'd1 || turn[31:30] == 2'd2) begin
      x = -x;
      turn = turn + 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      if (!turn[31]) begin
        nx = x - (y >>> i); y = y + (x >>> i); turn = turn - ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); turn = turn + ATAN_TBL[i];
      end
      x = nx;
    end
  endfunction

  function automatic pol_res_t polar_alu(input op_e op, input logic [31:0] am,
      input logic [15:0] aa, input logic [31:0] bm, input logic [15:0] ba);
    pol_res_t r;
    longint xa, ya, xb, yb, x, y, nx;
    logic [31:0] z, tb;
    logic [63:0] m;
    logic [95:0] q;
    r.status = ST_OK;
    m = 0;
    case (op)
      OP_ADD, OP_SUB: begin
        tb = {ba, 16'd0};
        if (op == OP_SUB) tb = tb + 32'h80000000;
        polar_to_xy(am, {aa, 16'd0}, xa, ya);
        polar_to_xy(bm, tb, xb, yb);
        x = xa + xb; y = ya + yb; z = 0;
        if (x == 0 && y == 0) begin
          m = 0; r.ang = 0;
        end else begin
          if (x < 0) begin x = -x; y = -y; z = 32'h80000000; end
          for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
              nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_TBL[i];
            end else begin
              nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_TBL[i];
            end
            x = nx;
          end
          if (x < 0) x = 0;
          m = unscale(64'(x));
          z = z + 32'h8000;
          r.ang = z[31:16];
        end
      end
      OP_MUL: begin
        m = (64'(am) * 64'(bm)) >> 16;
        r.ang = aa + ba;
      end
      default: begin
        r.ang = aa - ba;
        if (bm == 0) begin
          r.mag = '1; r.status = ST_DIVZERO;
          return r;
        end
        q = ({64'd0, am} << 16) / 96'(bm);
        m = (q > 96'hFFFFFFFF) ? 64'h1_0000_0000 : q[63:0];
      end
    endcase
    if (m > 64'hFFFFFFFF) begin
      m = 64'hFFFFFFFF; r.status = ST_SAT;
    end
    r.mag = m[31:0];
    return r;
  endfunction

  class result_board;
    pol_res_t pending[$];
    int errors;
    int checked;
    function void note_request(op_e op, logic [31:0] am, logic [15:0] aa,
                               logic [31:0] bm, logic [15:0] ba);
      pending.push_back(polar_alu(op, am, aa, bm, ba));
    endfunction
    function void check_result(logic [31:0] mag, logic [15:0] ang, logic [1:0] st);
      pol_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result mag=%h ang=%h status=%0d", mag, ang, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (mag !== e.mag) begin
        $error("res_mag: expected %h, got %h", e.mag, mag); errors++;
      end
      if (ang !== e.ang) begin
        $error("res_ang: expected %h, got %h", e.ang, ang); errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic valid_i = 0, stall_i = 0;
  logic [1:0] opcode_i = 0;
  logic [31:0] a_mag_i = 0, b_mag_i = 0;
  logic [15:0] a_ang_i = 0, b_ang_i = 0;
  logic stall_o, valid_o;
  logic [31:0] res_mag_o;
  logic [15:0] res_ang_o;
  logic [1:0] status_o;

  result_board board = new();
  int n_sent = 0;
  int op_cnt[4];
  bit long_hold_done = 0;

  always #5 clk_i = ~clk_i;

  polar_complex_alu i_dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      board.note_request(op_e'(opcode_i), a_mag_i, a_ang_i, b_mag_i, b_ang_i);
      n_sent++;
      op_cnt[opcode_i]++;
    end
    if (rst_ni && valid_o && !stall_i)
      board.check_result(res_mag_o, res_ang_o, status_o);
  end

  // receiver stall pattern plus one long hold-off
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && n_sent > 120) begin
        long_hold_done = 1;
        stall_i <= 1;
        repeat (60) @(posedge clk_i);
      end
      if ($urandom_range(0, 40) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: stall_i <= 0;
        1: stall_i <= ($urandom_range(0, 3) == 0);
        default: stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic send_req(input op_e op, input logic [31:0] am, input logic [15:0] aa,
                          input logic [31:0] bm, input logic [15:0] ba);
    valid_i  <= 1;
    opcode_i <= op;
    a_mag_i  <= am;
    a_ang_i  <= aa;
    b_mag_i  <= bm;
    b_ang_i  <= ba;
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return '1 - $urandom_range(0, 3);
      2: return $urandom >> $urandom_range(0, 31);
      3: return 32'h0001_0000 + ($urandom & 32'hFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    valid_i <= 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (board.pending.size() != 0 && guard < 20000);
  endtask

  initial begin
    op_e op;
    logic [31:0] m;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int k = 0; k < 4; k++) begin
      op = op_e'(k);
      send_req(op, 32'h0001_0000, 16'h0000, 32'h0001_0000, 16'h0000);
      send_req(op, '1, 16'h7FFF, '1, 16'h8000);
      send_req(op, 32'h0, 16'h8000, 32'h0, 16'h7FFF);
      send_req(op, 32'h0002_0000, 16'h4000, 32'h0002_0000, 16'hC000);
    end
    send_req(OP_SUB, 32'h0003_0000, 16'h1234, 32'h0003_0000, 16'h1234);
    send_req(OP_ADD, 32'h0003_0000, 16'h1000, 32'h0003_0000, 16'h9000);
    send_req(OP_MUL, 32'h8000_0000, 16'h0001, 32'h0004_0000, 16'hFFFF);
    send_req(OP_DIV, 32'hFFFF_0000, 16'h0100, 32'h0000_0001, 16'h0200);
    send_req(OP_DIV, 32'h1234_5678, 16'h0100, 32'h0, 16'h0200);
    send_req(OP_ADD, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0000);
    drain();
    while (n_sent < 440) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++) begin
        op = op_e'($urandom_range(0, 3));
        m = rand_mag();
        if ($urandom_range(0, 7) == 0) begin
          if (op == OP_SUB) send_req(op, m, 16'($urandom), m, 16'($urandom) & 16'h0);
          else send_req(op, m, 16'($urandom), rand_mag(), 16'($urandom));
        end else begin
          send_req(op, m, 16'($urandom), rand_mag(), 16'($urandom));
        end
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 6));
      if (n_sent > 300 && n_sent < 340) drain();
    end
    drain();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d results from %0d requests (add %0d, sub %0d, mul %0d, div %0d).",
             board.checked, n_sent, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** polar_complex_alu: PASSED **");
    end else begin
      if (board.pending.size() != 0)
        $error("%0d results never arrived", board.pending.size());
      $display("** polar_complex_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** polar_complex_alu: FAILED **");
    $finish;
  end
endmodule
